// ----- rtl/core/fir25_pkg.sv -----
// ----------------------------------------------------------------------------
// fir25_pkg
// Shared types and constants for the 25-tap FIR filter: sample and
// coefficient widths, accumulator width and the wavefront record that the
// tap cells pass along the chain.
// ----------------------------------------------------------------------------
package fir25_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int SEL_W    = 5;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  // Wide enough for a sum over up to 64 taps.
  localparam int ACC_W    = PROD_W + 6;
  localparam int FRAC_W   = 15;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COEF_SELECT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_VALUE  = CFG_IDX_W'(1);

  // One step of the accumulation wavefront.
  typedef struct packed {
    logic                    tok;
    logic signed [ACC_W-1:0] psum;
  } wave_t;

endpackage

// ----- rtl/core/fir25_cell.sv -----
// ----------------------------------------------------------------------------
// fir25_cell
// One tap of the filter: holds one delayed sample and one coefficient, and
// adds its product to the partial sum as the wavefront passes through.
// ----------------------------------------------------------------------------
module fir25_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                shift_en,
  input  logic signed [fir25_pkg::SAMPLE_W-1:0] x_in,
  output logic signed [fir25_pkg::SAMPLE_W-1:0] x_out,
  input  logic                                coef_we,
  input  logic signed [fir25_pkg::COEF_W-1:0]   coef_in,
  input  fir25_pkg::wave_t                    wave_in,
  output fir25_pkg::wave_t                    wave_out
);
  import fir25_pkg::*;

  logic signed [SAMPLE_W-1:0] x;
  logic signed [COEF_W-1:0]   coef;
  logic signed [PROD_W-1:0]   prod;

  assign prod  = coef * x;
  assign x_out = x;

  always_ff @(posedge clk) begin
    if (rst) begin
      x            <= '0;
      coef         <= '0;
      wave_out.tok <= 1'b0;
    end else begin
      if (shift_en) begin
        x <= x_in;
      end
      if (coef_we) begin
        coef <= coef_in;
      end
      wave_out.tok <= wave_in.tok;
      if (wave_in.tok) begin
        wave_out.psum <= wave_in.psum + ACC_W'(prod);
      end
    end
  end

endmodule

// ----- rtl/core/fir25_out.sv -----
// ----------------------------------------------------------------------------
// fir25_out
// Rounds and saturates the finished sum and presents it on the result
// channel, with a holding register for a result that finishes while the
// previous one is still stalled.
// ----------------------------------------------------------------------------
module fir25_out (
  input  logic                                  clk,
  input  logic                                  rst,
  input  fir25_pkg::wave_t                      wave_in,
  output logic                                  pending,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [fir25_pkg::SAMPLE_W-1:0] filtered,
  output logic                                  clipped
);
  import fir25_pkg::*;

  localparam int Q_W = ACC_W - FRAC_W;

  logic signed [ACC_W-1:0]    biased;
  logic signed [Q_W-1:0]      q;
  logic                       over;
  logic signed [SAMPLE_W-1:0] rnd_val;
  logic                       rnd_clip;
  logic signed [SAMPLE_W-1:0] hold_val;
  logic                       hold_clip;
  logic                       hold_tok_valid;
  logic                       free;

  // Round half up, then floor by the arithmetic shift.
  assign biased = wave_in.psum + ACC_W'(1 << (FRAC_W - 1));
  assign q      = Q_W'(biased >>> FRAC_W);

  // The value fits when every bit above the 16-bit result matches its sign.
  assign over = (q[Q_W-1:SAMPLE_W-1] != {(Q_W - SAMPLE_W + 1){1'b0}}) &&
                (q[Q_W-1:SAMPLE_W-1] != {(Q_W - SAMPLE_W + 1){1'b1}});

  always_comb begin
    rnd_clip = over;
    if (!over) begin
      rnd_val = q[SAMPLE_W-1:0];
    end else if (q[Q_W-1]) begin
      rnd_val = {1'b1, {(SAMPLE_W - 1){1'b0}}};
    end else begin
      rnd_val = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    end
  end

  assign free    = !result_valid || !result_stall;
  assign pending = hold_tok_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid   <= 1'b0;
      hold_tok_valid <= 1'b0;
    end else if (free) begin
      if (hold_tok_valid) begin
        filtered       <= hold_val;
        clipped        <= hold_clip;
        result_valid   <= 1'b1;
        hold_tok_valid <= 1'b0;
      end else if (wave_in.tok) begin
        filtered     <= rnd_val;
        clipped      <= rnd_clip;
        result_valid <= 1'b1;
      end else begin
        result_valid <= 1'b0;
      end
    end else if (wave_in.tok) begin
      hold_val       <= rnd_val;
      hold_clip      <= rnd_clip;
      hold_tok_valid <= 1'b1;
    end
  end

endmodule

// ----- rtl/core/fir_filter_25_tap.sv -----
// ----------------------------------------------------------------------------
// fir_filter_25_tap
// Streaming direct-form FIR filter built as a chain of tap cells.
// ----------------------------------------------------------------------------
// Each accepted sample produces exactly one result: the sum over all taps of
// coefficient times delayed sample (the newest sample on tap zero, earlier
// samples counted as zero after reset), shifted right by 15 with round half
// up and saturated to 16 bits, with clipped set when saturation occurred.
// The result of a sample request is registered in the output stage once its
// wavefront has left the tap chain, and with an unstalled result channel the
// next request can then be accepted. The block works on one sample at a
// time because the partial sum walks through the TAPS tap cells one cell per
// cycle, each cell holding its own sample and coefficient. A finished result
// may wait on a stalled result channel while the next sample request is
// accepted and computed; the new result then waits in a holding register. Coefficients are loaded through an
// indirect pair: register 0 selects a tap and a write of register 1 loads
// that tap's coefficient (a select of TAPS or more loads nothing). The
// configuration port is always ready; writes are expected only while the
// filter is idle.
// ----------------------------------------------------------------------------
module fir_filter_25_tap #(
  parameter int TAPS = 25
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   sample_valid,
  output logic                                   sample_stall,
  input  logic signed [fir25_pkg::SAMPLE_W-1:0]  sample,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic signed [fir25_pkg::SAMPLE_W-1:0]  filtered,
  output logic                                   clipped,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [fir25_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fir25_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import fir25_pkg::*;

  // Configuration: the select register is the only one with visible state.
  logic [SEL_W-1:0] coef_select;
  logic             cfg_wr;
  logic             coef_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign coef_wr   = cfg_wr && (cfg_index == REG_COEF_VALUE);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_select <= '0;
    end else if (cfg_wr && (cfg_index == REG_COEF_SELECT)) begin
      coef_select <= cfg_data[SEL_W-1:0];
    end
  end

  // Input control. A request shifts the delay line at once; the wavefront
  // is launched into the first cell in the following cycle.
  logic accept;
  logic go;
  logic wave_active;
  logic pending;

  assign sample_stall = wave_active || pending;
  assign accept       = sample_valid && !sample_stall;

  wave_t                      wave [TAPS+1];
  logic signed [SAMPLE_W-1:0] xs   [TAPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      go          <= 1'b0;
      wave_active <= 1'b0;
    end else begin
      go <= accept;
      if (accept) begin
        wave_active <= 1'b1;
      end else if (wave[TAPS].tok) begin
        wave_active <= 1'b0;
      end
    end
  end

  assign wave[0].tok  = go;
  assign wave[0].psum = '0;
  assign xs[0]        = sample;

  // The tap chain: samples move one cell along per request, the partial sum
  // moves one cell along per cycle.
  for (genvar k = 0; k < TAPS; k++) begin : g_tap
    logic we;
    assign we = coef_wr && (32'(coef_select) == k);

    fir25_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift_en (accept),
      .x_in     (xs[k]),
      .x_out    (xs[k+1]),
      .coef_we  (we),
      .coef_in  (cfg_data[COEF_W-1:0]),
      .wave_in  (wave[k]),
      .wave_out (wave[k+1])
    );
  end

  fir25_out u_out (
    .clk          (clk),
    .rst          (rst),
    .wave_in      (wave[TAPS]),
    .pending      (pending),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .filtered     (filtered),
    .clipped      (clipped)
  );

endmodule

// ----- sim/tb_fir_filter_25_tap.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fir_filter_25_tap
// Self-checking testbench for the streaming 25-tap FIR filter. A predictor
// mirrors the coefficient store and the sample history and computes each
// expected output, which a monitor compares field by field with what the
// filter returns. Directed tests cover reset state, start of stream,
// rounding, saturation and the coefficient select rules. Random phases then
// stream samples with varying input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_fir_filter_25_tap;
  import fir25_pkg::*;

  localparam int TAPS             = 25;
  // Allowance for the delay of a result, used by the final wait.
  localparam int LATENCY          = TAPS + 1;
  localparam int RANDOM_PER_PHASE = 125;
  localparam int MAX_REPORTS      = 200;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  typedef struct packed {
    sample_t filtered;
    logic    clipped;
  } fir_result_t;

  localparam sample_t SAMPLE_MIN = sample_t'(16'h8000);
  localparam sample_t SAMPLE_MAX = sample_t'(16'h7FFF);
  localparam coef_t   COEF_MIN   = coef_t'(16'h8000);
  localparam coef_t   COEF_MAX   = coef_t'(16'h7FFF);
  localparam longint  OUT_MIN    = -32768;
  localparam longint  OUT_MAX    = 32767;
  localparam longint  HALF_LSB   = 64'sd1 <<< (FRAC_W - 1);

  // Register indexes that the filter does not decode, and select values
  // that point past the last tap.
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = '1;
  localparam int                   SEL_LAST         = (1 << SEL_W) - 1;
  localparam int                   SEL_PROBE        = 3;

  // Block ports; every input has a known value from time zero.
  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  sample_t               sample       = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  sample_t               filtered;
  logic                  clipped;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  // Predictor state: coefficient store, select register and the previous
  // TAPS - 1 samples, newest first. All zero after reset.
  coef_t            coef_shadow [TAPS];
  sample_t          history     [TAPS-1];
  logic [SEL_W-1:0] select_shadow = '0;

  // Coefficient set that the next load will write, tap by tap.
  coef_t coef_plan [TAPS];

  // Expected outputs, oldest first.
  fir_result_t expected_outputs [$];

  int errors          = 0;
  int samples_sent    = 0;
  int results_checked = 0;
  int clips_seen      = 0;
  int cfg_writes      = 0;

  // Percent of cycles in which the sender holds back or the receiver stalls.
  int send_idle_pct = 0;
  int stall_pct     = 0;

  fir_filter_25_tap #(
    .TAPS(TAPS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample      (sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .filtered    (filtered),
    .clipped     (clipped),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #10 clk = ~clk;

  initial begin
    foreach (coef_shadow[k]) coef_shadow[k] = '0;
    foreach (history[k]) history[k] = '0;
    foreach (coef_plan[k]) coef_plan[k] = '0;
  end

  // Computes the output for one accepted sample and shifts it into the
  // history. The sum is exact in 64 bits; adding half an LSB before the
  // arithmetic shift gives round half up, i.e. floor((acc + 2^14) / 2^15).
  function automatic fir_result_t fir_predict(input sample_t s);
    longint      acc;
    longint      q;
    fir_result_t r;
    acc = longint'(coef_shadow[0]) * longint'(s);
    for (int j = 1; j < TAPS; j++) begin
      acc += longint'(coef_shadow[j]) * longint'(history[j-1]);
    end
    for (int j = TAPS - 2; j > 0; j--) begin
      history[j] = history[j-1];
    end
    history[0] = s;
    q = (acc + HALF_LSB) >>> FRAC_W;
    r.clipped = 1'b1;
    if (q > OUT_MAX) begin
      r.filtered = SAMPLE_MAX;
    end else if (q < OUT_MIN) begin
      r.filtered = SAMPLE_MIN;
    end else begin
      r.filtered = sample_t'(q);
      r.clipped  = 1'b0;
    end
    return r;
  endfunction

  // Mostly small coefficients so that many outputs stay in range, with the
  // extremes, zero and full-range values mixed in.
  function automatic coef_t random_coef();
    case ($urandom_range(9))
      0:       return COEF_MIN;
      1:       return COEF_MAX;
      2:       return '0;
      8, 9:    return coef_t'($urandom);
      default: return coef_t'(int'($urandom_range(4095)) - 2048);
    endcase
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(9))
      0:          return SAMPLE_MIN;
      1:          return SAMPLE_MAX;
      2, 3, 4:    return sample_t'(int'($urandom_range(2047)) - 1024);
      default:    return sample_t'($urandom);
    endcase
  endfunction

  // Sends one sample request. Valid stays high on return so that a
  // back-to-back request does not lower and raise it in the same step; the
  // random hold-off before the request lowers it when a gap is wanted.
  task automatic push_sample(input sample_t s);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    expected_outputs.push_back(fir_predict(s));
    samples_sent++;
  endtask

  // Stops the sample stream and waits until every expected output has come
  // back, so the filter is idle and its registers may be written.
  task automatic drain_results();
    sample_valid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
  endtask

  // Writes one register and applies the same write to the predictor. A
  // value write loads the store only when the select points at a real tap;
  // writes to undecoded indexes change nothing.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_writes++;
    case (idx)
      REG_COEF_SELECT: select_shadow = data[SEL_W-1:0];
      REG_COEF_VALUE: begin
        if (select_shadow < TAPS) coef_shadow[select_shadow] = coef_t'(data);
      end
      default: ;
    endcase
  endtask

  task automatic close_config();
    cfg_valid <= 1'b0;
  endtask

  task automatic load_coef_plan();
    for (int k = 0; k < TAPS; k++) begin
      write_reg(REG_COEF_SELECT, CFG_DATA_W'(k));
      write_reg(REG_COEF_VALUE, CFG_DATA_W'(coef_plan[k]));
    end
  endtask

  // A stray write: any select (upper data bits and out-of-range taps
  // included), a value for whatever tap is selected, or an undecoded index.
  task automatic random_reg_write();
    case ($urandom_range(3))
      0:       write_reg(REG_COEF_SELECT, CFG_DATA_W'($urandom));
      1, 2:    write_reg(REG_COEF_VALUE, CFG_DATA_W'($urandom));
      default: write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
                         CFG_DATA_W'($urandom));
    endcase
  endtask

  // With the store still at its reset value of zero, the output must be zero
  // even for the most negative sample.
  task automatic test_reset_state();
    drain_results();
    push_sample(SAMPLE_MIN);
  endtask

  // Loads a ramp right at the start of the stream; taps that reach past the
  // first samples must see zeros from the cleared delay line.
  task automatic test_start_of_stream();
    drain_results();
    foreach (coef_plan[k]) coef_plan[k] = coef_t'((k + 1) * 1200);
    load_coef_plan();
    close_config();
    push_sample(SAMPLE_MAX);
    push_sample(sample_t'(1));
    push_sample(sample_t'(-1));
  endtask

  // Only tap zero is set, to one LSB, so the sum equals the sample and the
  // rounding boundary around one half can be probed from both sides.
  task automatic test_rounding();
    drain_results();
    foreach (coef_plan[k]) coef_plan[k] = '0;
    coef_plan[0] = coef_t'(1);
    load_coef_plan();
    close_config();
    push_sample(sample_t'(16384));
    push_sample(sample_t'(16383));
    push_sample(sample_t'(-16384));
    push_sample(sample_t'(-16385));
  endtask

  // Every coefficient at minus one: two most negative samples drive the sum
  // far past the top, then a run of most positive samples far past the bottom;
  // with every coefficient at its maximum, two more of those drive it past the top.
  task automatic test_saturation();
    drain_results();
    foreach (coef_plan[k]) coef_plan[k] = COEF_MIN;
    load_coef_plan();
    close_config();
    repeat (2) push_sample(SAMPLE_MIN);
    repeat (4) push_sample(SAMPLE_MAX);
    drain_results();
    foreach (coef_plan[k]) coef_plan[k] = COEF_MAX;
    load_coef_plan();
    close_config();
    repeat (2) push_sample(SAMPLE_MAX);
  endtask

  // One tap is loaded normally; value writes with the select past the last
  // tap, writes to undecoded indexes and a lone select write must all leave
  // the store alone. The samples that follow expose any stray load.
  task automatic test_select_rules();
    drain_results();
    foreach (coef_plan[k]) coef_plan[k] = '0;
    load_coef_plan();
    write_reg(REG_COEF_SELECT, CFG_DATA_W'(SEL_PROBE));
    write_reg(REG_COEF_VALUE, CFG_DATA_W'(5000));
    write_reg(REG_COEF_SELECT, CFG_DATA_W'(TAPS));
    write_reg(REG_COEF_VALUE, CFG_DATA_W'(-1234));
    write_reg(REG_COEF_SELECT, CFG_DATA_W'(SEL_LAST));
    write_reg(REG_COEF_VALUE, CFG_DATA_W'(777));
    write_reg(REG_FIRST_UNUSED, CFG_DATA_W'(-4321));
    write_reg(REG_LAST_UNUSED, '1);
    write_reg(REG_COEF_SELECT, '0);
    close_config();
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MIN);
    push_sample(sample_t'(12345));
    push_sample(sample_t'(-1));
  endtask

  // Random coefficients and samples under one idling mode. Halfway through,
  // the stream pauses and a few taps are retuned with stray writes mixed in.
  task automatic test_random_stream(input int idle_pct, input int stall_rate);
    drain_results();
    send_idle_pct = idle_pct;
    stall_pct     = stall_rate;
    foreach (coef_plan[k]) coef_plan[k] = random_coef();
    load_coef_plan();
    repeat ($urandom_range(1, 3)) random_reg_write();
    close_config();
    for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
      push_sample(random_sample());
      if (n == RANDOM_PER_PHASE / 2) begin
        drain_results();
        repeat ($urandom_range(2, 6)) begin
          write_reg(REG_COEF_SELECT, CFG_DATA_W'($urandom_range(TAPS - 1)));
          write_reg(REG_COEF_VALUE, CFG_DATA_W'(random_coef()));
        end
        repeat ($urandom_range(1, 3)) random_reg_write();
        close_config();
      end
    end
  endtask

  // Receiver backpressure: a fresh stall decision every cycle.
  always @(posedge clk) begin
    result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Result monitor. Ports are sampled right after the edge, before any
  // register update of that edge takes effect, so a result counts when
  // valid was high and stall low going into the edge.
  always @(posedge clk) begin : result_checker
    fir_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_outputs.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("unexpected result: filtered %0d, clipped %0b", filtered, clipped);
      end else begin
        want = expected_outputs.pop_front();
        results_checked++;
        if (want.clipped) clips_seen++;
        if (filtered !== want.filtered) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $error("filtered: expected %0d, got %0d", want.filtered, filtered);
        end
        if (clipped !== want.clipped) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $error("clipped: expected %0b, got %0b", want.clipped, clipped);
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_start_of_stream();
    test_rounding();
    test_saturation();
    test_select_rules();

    test_random_stream(0, 0);
    test_random_stream(63, 0);
    test_random_stream(0, 63);
    test_random_stream(38, 38);

    // Wait for the last result, then a while longer to catch any extra one.
    drain_results();
    repeat (LATENCY + 8) @(posedge clk);

    $display("Checked %0d outputs (%0d saturated) for %0d samples and %0d register writes.",
             results_checked, clips_seen, samples_sent, cfg_writes);
    $display("Covered reset, start of stream, rounding, clipping, select rules and four idling modes.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("Timeout: %0d outputs still outstanding.", expected_outputs.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
